[sv/sbcp_pkg.sv]
// ----------------------------------------------------------------------------
// sbcp_pkg
// Shared types and constants of the strand bias counter with phi statistic.
// ----------------------------------------------------------------------------
`default_nettype none

package sbcp_pkg;

  localparam int unsigned NUM_SITES_DEF  = 4096;
  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned BINS_PER_SITE  = 6;
  localparam int unsigned BIN_BITS       = 3;
  localparam int unsigned SITE_BITS      = 12;
  localparam int unsigned OUT_BITS       = 24;
  localparam int unsigned STAT_BITS      = 8;
  localparam int unsigned K_BITS         = 7;
  localparam int unsigned MARGIN_MIN     = 4;
  localparam int unsigned STAT_SCALE     = 50;

  localparam logic       KIND_COUNT    = 1'b0;
  localparam logic       KIND_REPORT   = 1'b1;
  localparam logic [1:0] ALLELE_UNUSED = 2'd3;

  typedef struct packed {
    logic                 kind;
    logic [SITE_BITS-1:0] site_index;
    logic [1:0]           allele_code;
    logic                 strand;
  } in_item_t;

  typedef struct packed {
    logic [SITE_BITS-1:0]        report_site;
    logic [OUT_BITS-1:0]         count_a_fwd;
    logic [OUT_BITS-1:0]         count_a_rev;
    logic [OUT_BITS-1:0]         count_b_fwd;
    logic [OUT_BITS-1:0]         count_b_rev;
    logic [OUT_BITS-1:0]         count_o_fwd;
    logic [OUT_BITS-1:0]         count_o_rev;
    logic signed [STAT_BITS-1:0] strand_stat;
  } out_item_t;

endpackage

`default_nettype wire

[sv/sbcp_stream_if.sv]
// ----------------------------------------------------------------------------
// sbcp_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbcp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/sbcp_ram.sv]
// ----------------------------------------------------------------------------
// sbcp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sbcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/strand_bias_count_and_phi_top.sv]
// ----------------------------------------------------------------------------
// strand_bias_count_and_phi_top
// Per-site strand counters with a phi-style strand statistic on report.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  in_i    | in  | count or report request (kind, site, allele, strand)
//  out_o   | out | site, six counts, strand statistic
//
//  After reset a clearing pass zeroes every site, with in_i not ready.
//  A count beat does a RAM read, then a saturating write back.
//  A report beat skips the products when the site is out of range or a
//  margin is four or less; else every product runs through one shared
//  shift-add multiplier, one multiplier bit per cycle, and the rounding
//  search runs seven such products.
//  in_i is ready only in idle; a report waits while out_o holds a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module strand_bias_count_and_phi_top #(
  parameter int unsigned NUM_SITES  = sbcp_pkg::NUM_SITES_DEF,
  parameter int unsigned COUNT_BITS = sbcp_pkg::COUNT_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sbcp_stream_if.sink   in_i,
  sbcp_stream_if.source out_o
);

  localparam int unsigned AW  = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
  localparam int unsigned W   = 4 * COUNT_BITS + 24;
  localparam int unsigned CW  = (COUNT_BITS > sbcp_pkg::OUT_BITS) ?
                                COUNT_BITS : sbcp_pkg::OUT_BITS;
  localparam int unsigned NB  = sbcp_pkg::BINS_PER_SITE;
  localparam int unsigned KB  = sbcp_pkg::K_BITS;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CNT   = 3'd2;
  localparam logic [2:0] S_RPT   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_POST  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [2:0] OP_P   = 3'd0;
  localparam logic [2:0] OP_Q   = 3'd1;
  localparam logic [2:0] OP_T   = 3'd2;
  localparam logic [2:0] OP_L   = 3'd3;
  localparam logic [2:0] OP_D1  = 3'd4;
  localparam logic [2:0] OP_D2  = 3'd5;
  localparam logic [2:0] OP_DEN = 3'd6;
  localparam logic [2:0] OP_K   = 3'd7;

  sbcp_pkg::in_item_t  in_p;
  sbcp_pkg::out_item_t out_q, out_d;

  logic [2:0]            state_q, state_d;
  logic [2:0]            op_q, op_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [sbcp_pkg::SITE_BITS-1:0] site_q, site_d;
  logic [sbcp_pkg::BIN_BITS-1:0]  bin_q, bin_d;
  logic                  cnt_ok_q, cnt_ok_d;
  logic                  in_rng_q, in_rng_d;
  logic                  out_valid_q, out_valid_d;
  logic [COUNT_BITS-1:0] c_q [NB];
  logic [COUNT_BITS-1:0] c_d [NB];
  logic [W-1:0]          mc_q, mc_d, mp_q, mp_d, acc_q, acc_d;
  logic [W-1:0]          p_q, p_d, lhs_q, lhs_d, den_q, den_d;
  logic                  neg_q, neg_d;
  logic [KB-1:0]         r_q, r_d;
  logic [2:0]            bit_q, bit_d;

  logic [COUNT_BITS-1:0] rdata [NB];
  logic [NB-1:0]         bank_we;
  logic [AW-1:0]         waddr, raddr;
  logic [COUNT_BITS-1:0] wdata, cur;
  logic                  in_rng_now;
  logic [KB-1:0]         cand;
  logic [KB:0]           odd;
  logic [2*KB+1:0]       sq;
  logic [W-1:0]          s01, s23, s02, s13;
  logic [CW-1:0]         cw [NB];
  logic [sbcp_pkg::OUT_BITS-1:0] cnt_out [NB];
  logic [sbcp_pkg::STAT_BITS-1:0] stat;

  assign in_p        = in_i.payload;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  assign in_rng_now = (32'(in_p.site_index) < 32'(NUM_SITES));
  assign raddr      = (state_q == S_IDLE) ? AW'(in_p.site_index) : AW'(site_q);
  assign waddr      = (state_q == S_CLEAR) ? clr_q : AW'(site_q);
  assign cur        = rdata[bin_q];
  assign wdata      = (state_q == S_CLEAR) ? '0 : ((&cur) ? cur : cur + 1'b1);

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      bank_we[b] = (state_q == S_CLEAR) ||
                   ((state_q == S_CNT) && cnt_ok_q && (bin_q == b[sbcp_pkg::BIN_BITS-1:0]));
    end
  end

  for (genvar g = 0; g < NB; g++) begin : g_bank
    sbcp_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(NUM_SITES)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (bank_we[g]),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .raddr_i(raddr),
      .rdata_o(rdata[g])
    );
  end

  assign cand = r_q | (KB'(1) << bit_q);
  assign odd  = {cand, 1'b0} - (KB+1)'(1);
  assign sq   = (2*KB+2)'(odd) * (2*KB+2)'(odd);
  assign s01  = W'(c_q[0]) + W'(c_q[1]) + W'(1);
  assign s23  = W'(c_q[2]) + W'(c_q[3]) + W'(1);
  assign s02  = W'(c_q[0]) + W'(c_q[2]) + W'(1);
  assign s13  = W'(c_q[1]) + W'(c_q[3]) + W'(1);
  assign stat = neg_q ? (sbcp_pkg::STAT_BITS'(0) - sbcp_pkg::STAT_BITS'(r_q))
                      : sbcp_pkg::STAT_BITS'(r_q);

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      cw[b]      = CW'(c_q[b]);
      cnt_out[b] = (cw[b] > CW'({sbcp_pkg::OUT_BITS{1'b1}})) ?
                   {sbcp_pkg::OUT_BITS{1'b1}} : sbcp_pkg::OUT_BITS'(cw[b]);
    end
  end

  always_comb begin
    logic [COUNT_BITS:0] m01, m23, m02, m13;
    state_d     = state_q;
    op_d        = op_q;
    clr_d       = clr_q;
    site_d      = site_q;
    bin_d       = bin_q;
    cnt_ok_d    = cnt_ok_q;
    in_rng_d    = in_rng_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    c_d         = c_q;
    mc_d        = mc_q;
    mp_d        = mp_q;
    acc_d       = acc_q;
    p_d         = p_q;
    lhs_d       = lhs_q;
    den_d       = den_q;
    neg_d       = neg_q;
    r_d         = r_q;
    bit_d       = bit_q;
    m01 = (COUNT_BITS+1)'(rdata[0]) + (COUNT_BITS+1)'(rdata[1]);
    m23 = (COUNT_BITS+1)'(rdata[2]) + (COUNT_BITS+1)'(rdata[3]);
    m02 = (COUNT_BITS+1)'(rdata[0]) + (COUNT_BITS+1)'(rdata[2]);
    m13 = (COUNT_BITS+1)'(rdata[1]) + (COUNT_BITS+1)'(rdata[3]);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == 32'(NUM_SITES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          site_d   = in_p.site_index;
          bin_d    = {in_p.allele_code, in_p.strand};
          cnt_ok_d = in_rng_now && (in_p.allele_code != sbcp_pkg::ALLELE_UNUSED);
          in_rng_d = in_rng_now;
          state_d  = (in_p.kind == sbcp_pkg::KIND_COUNT) ? S_CNT : S_RPT;
        end
      end
      S_CNT: begin
        state_d = S_IDLE;
      end
      S_RPT: begin
        r_d   = '0;
        neg_d = 1'b0;
        for (int b = 0; b < NB; b++) begin
          c_d[b] = in_rng_q ? rdata[b] : '0;
        end
        op_d = OP_P;
        if (in_rng_q && m01 > (COUNT_BITS+1)'(sbcp_pkg::MARGIN_MIN) &&
            m23 > (COUNT_BITS+1)'(sbcp_pkg::MARGIN_MIN) &&
            m02 > (COUNT_BITS+1)'(sbcp_pkg::MARGIN_MIN) &&
            m13 > (COUNT_BITS+1)'(sbcp_pkg::MARGIN_MIN)) begin
          state_d = S_LOAD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_LOAD: begin
        acc_d   = '0;
        state_d = S_MUL;
        case (op_q)
          OP_P: begin
            mc_d = W'({c_q[0], 1'b1});
            mp_d = W'({c_q[3], 1'b1});
          end
          OP_Q: begin
            mc_d = W'({c_q[1], 1'b1});
            mp_d = W'({c_q[2], 1'b1});
          end
          OP_T: begin
            mc_d = p_q;
            mp_d = W'(sbcp_pkg::STAT_SCALE);
          end
          OP_L: begin
            mc_d = p_q;
            mp_d = p_q;
          end
          OP_D1: begin
            mc_d = s01;
            mp_d = s23;
          end
          OP_D2: begin
            mc_d = s02;
            mp_d = s13;
          end
          OP_DEN: begin
            mc_d = p_q;
            mp_d = den_q;
          end
          default: begin
            mc_d = den_q;
            mp_d = W'(sq);
          end
        endcase
      end
      S_MUL: begin
        if (mp_q == '0) begin
          state_d = S_POST;
        end else begin
          acc_d = acc_q + (mp_q[0] ? mc_q : '0);
          mc_d  = mc_q << 1;
          mp_d  = mp_q >> 1;
        end
      end
      S_POST: begin
        state_d = S_LOAD;
        case (op_q)
          OP_P: begin
            p_d  = acc_q;
            op_d = OP_Q;
          end
          OP_Q: begin
            neg_d = (p_q < acc_q);
            p_d   = (p_q < acc_q) ? (acc_q - p_q) : (p_q - acc_q);
            op_d  = OP_T;
          end
          OP_T: begin
            p_d  = acc_q;
            op_d = OP_L;
          end
          OP_L: begin
            lhs_d = acc_q;
            op_d  = OP_D1;
          end
          OP_D1: begin
            p_d  = acc_q;
            op_d = OP_D2;
          end
          OP_D2: begin
            den_d = acc_q;
            op_d  = OP_DEN;
          end
          OP_DEN: begin
            den_d = acc_q;
            op_d  = OP_K;
            bit_d = 3'(KB - 1);
            r_d   = '0;
          end
          default: begin
            if (acc_q <= lhs_q) begin
              r_d = cand;
            end
            if (bit_q == '0) begin
              state_d = S_DONE;
            end else begin
              bit_d = bit_q - 1'b1;
            end
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.report_site = site_q;
          out_d.count_a_fwd = cnt_out[0];
          out_d.count_a_rev = cnt_out[1];
          out_d.count_b_fwd = cnt_out[2];
          out_d.count_b_rev = cnt_out[3];
          out_d.count_o_fwd = cnt_out[4];
          out_d.count_o_rev = cnt_out[5];
          out_d.strand_stat = signed'(stat);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_P;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      bit_q       <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    site_q   <= site_d;
    bin_q    <= bin_d;
    cnt_ok_q <= cnt_ok_d;
    in_rng_q <= in_rng_d;
    out_q    <= out_d;
    c_q      <= c_d;
    mc_q     <= mc_d;
    mp_q     <= mp_d;
    acc_q    <= acc_d;
    p_q      <= p_d;
    lhs_q    <= lhs_d;
    den_q    <= den_d;
    neg_q    <= neg_d;
    r_q      <= r_d;
  end

  a_cnt_one_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CNT) |-> $onehot0(bank_we))
    else $error("count write hits more than one bank");

  a_rpt_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_p.kind == sbcp_pkg::KIND_REPORT) |=> !in_i.ready)
    else $error("report beat did not block input");

  a_stat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.strand_stat != -8'sd128))
    else $error("strand statistic out of range");

  a_k_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POST && op_q == OP_K) |-> (bit_q < 3'(KB)))
    else $error("rounding search bit out of range");

endmodule

`default_nettype wire
